>>> hw/rtl/frame_slot_pool_allocator_assert.svh
// Assertion macros for the checker of the slot pool.
// Both expect clk and rst_n to be visible where they are used.
`ifndef FRAME_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define FRAME_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define FSPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot pool check failed");

// Next-cycle implication
`define FSPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot pool check failed");

`endif

>>> hw/rtl/fspa_pkg.sv
package fspa_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY = 1'd1;

    // Operation codes
    localparam logic [2:0] MODE_ALLOC   = 3'd0;
    localparam logic [2:0] MODE_REF     = 3'd1;
    localparam logic [2:0] MODE_RELEASE = 3'd2;
    localparam logic [2:0] MODE_FORCE   = 3'd3;
    localparam logic [2:0] MODE_DROP    = 3'd4;
    localparam logic [2:0] MODE_LOOKUP  = 3'd5;

    // Result codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_LAST   = 3'd1;
    localparam logic [2:0] ST_BAD    = 3'd2;
    localparam logic [2:0] ST_STALE  = 3'd3;
    localparam logic [2:0] ST_DOUBLE = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;

    localparam logic [15:0] REF_MAX    = 16'hFFFF;
    localparam logic [6:0]  USE_MAX    = 7'd127;
    localparam logic [6:0]  EXPIRE_MAX = 7'd127;
    // Slot count never exceeds what the 7-bit active register can name
    localparam int SLOT_CAP = 128;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] slot_index;
        logic [15:0] cookie_gen;
        logic [31:0] current_tick;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  granted_slot;
        logic [15:0] granted_gen;
        logic [31:0] slot_birth;
        logic [6:0]  expired_count;
        logic [6:0]  free_slots;
        logic [6:0]  used_slots;
    } out_word_t;

    // One slot as held in memory
    typedef struct packed {
        logic [15:0] ref_cnt;
        logic [15:0] gen;
        logic [31:0] birth;
    } slot_entry_t;

    // How an accepted word is handled
    typedef enum logic [1:0] {
        K_QUICK,
        K_SINGLE,
        K_SCAN
    } kind_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic eval;
        logic scan_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  clear_last;
        logic  scan_done;
    } dp_stat_t;

endpackage

>>> hw/rtl/fspa_ram.sv
module fspa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/fspa_ctrl.sv
module fspa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  fspa_pkg::dp_stat_t   stat,
    output fspa_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and datapath commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    case (stat.kind)
                        fspa_pkg::K_SINGLE: state_next = S_EVAL;
                        fspa_pkg::K_SCAN:   state_next = S_SCAN;
                        default:            state_next = S_FINISH;
                    endcase
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hand over once the output register is free or being drained
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

>>> hw/rtl/fspa_datapath.sv
module fspa_datapath #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fspa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  fspa_pkg::in_word_t                  req,
    input  fspa_pkg::ctrl_cmd_t                 cmd,
    output fspa_pkg::dp_stat_t                  stat,
    output fspa_pkg::out_word_t                 rsp
);

    // Slots at or above the cap can never be addressed
    localparam int DEPTH = (NUM_SLOTS < fspa_pkg::SLOT_CAP) ? NUM_SLOTS : fspa_pkg::SLOT_CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam logic [7:0]    CAP      = 8'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [6:0]  active_reg;
    logic [31:0] expiry_reg;
    fspa_pkg::in_word_t  in_reg;
    logic [6:0]  in_use_reg;
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] chk_reg;
    logic          rd_vld_reg;

    logic [2:0]  res_status_reg;
    logic [5:0]  res_gslot_reg;
    logic [15:0] res_ggen_reg;
    logic [31:0] res_birth_reg;
    logic [6:0]  res_expired_reg;
    fspa_pkg::out_word_t rsp_reg;

    logic [6:0]  count;
    logic [6:0]  free_cnt;
    logic        req_in_range;
    fspa_pkg::kind_t kind;
    logic [2:0]  quick_status;
    logic [7:0]  ptr8;
    logic [7:0]  chk8;
    logic        issue;
    logic        is_alloc;

    fspa_pkg::slot_entry_t ent;
    logic [fspa_pkg::CFG_DATA_W-1:0] age;
    logic        re;
    logic [AW-1:0] raddr;
    logic        we;
    logic [AW-1:0] waddr;
    fspa_pkg::slot_entry_t wdata;
    logic        use_up;
    logic        use_down;
    logic        set_status;
    logic [2:0]  new_status;
    logic        set_birth;
    logic        set_grant;
    logic        exp_inc;

    // Effective slot count
    always_comb
    begin
        count = ({1'b0, active_reg} > CAP) ? CAP[6:0] : active_reg;
    end

    assign free_cnt = (count > in_use_reg) ? (count - in_use_reg) : 7'd0;

    // Decode of the word at the input
    assign req_in_range = (req.slot_index < {9'd0, count});

    always_comb
    begin
        kind         = fspa_pkg::K_QUICK;
        quick_status = fspa_pkg::ST_BAD;
        case (req.mode)
            fspa_pkg::MODE_ALLOC:
            begin
                kind = fspa_pkg::K_SCAN;
            end
            fspa_pkg::MODE_REF, fspa_pkg::MODE_RELEASE,
            fspa_pkg::MODE_FORCE, fspa_pkg::MODE_LOOKUP:
            begin
                kind = req_in_range ? fspa_pkg::K_SINGLE : fspa_pkg::K_QUICK;
            end
            fspa_pkg::MODE_DROP:
            begin
                // expiry off: answer at once, nothing freed
                kind         = (expiry_reg == '0) ? fspa_pkg::K_QUICK : fspa_pkg::K_SCAN;
                quick_status = fspa_pkg::ST_OK;
            end
            default:
            begin
                kind = fspa_pkg::K_QUICK;
            end
        endcase
    end

    // Scan pointer bookkeeping
    assign ptr8     = 8'(ptr_reg);
    assign chk8     = 8'(chk_reg);
    assign issue    = (ptr8 < {1'b0, count});
    assign is_alloc = (in_reg.mode == fspa_pkg::MODE_ALLOC);

    // Memory read port
    assign re    = (cmd.accept && (kind == fspa_pkg::K_SINGLE)) || (cmd.scan_step && issue);
    assign raddr = cmd.scan_step ? ptr_reg[AW-1:0] : req.slot_index[AW-1:0];

    assign age = in_reg.current_tick - ent.birth;

    // Slot update for single ops, scan steps and the clearing pass
    always_comb
    begin
        we         = 1'b0;
        waddr      = in_reg.slot_index[AW-1:0];
        wdata      = ent;
        use_up     = 1'b0;
        use_down   = 1'b0;
        set_status = 1'b0;
        new_status = fspa_pkg::ST_OK;
        set_birth  = 1'b0;
        set_grant  = 1'b0;
        exp_inc    = 1'b0;

        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = ptr_reg[AW-1:0];
            wdata = '0;
        end
        else if (cmd.eval)
        begin
            set_status = 1'b1;
            case (in_reg.mode)
                fspa_pkg::MODE_REF:
                begin
                    if (ent.ref_cnt == '0 || ent.gen != in_reg.cookie_gen)
                    begin
                        new_status = fspa_pkg::ST_STALE;
                    end
                    else if (ent.ref_cnt == fspa_pkg::REF_MAX)
                    begin
                        new_status = fspa_pkg::ST_BAD;
                    end
                    else
                    begin
                        we            = 1'b1;
                        wdata.ref_cnt = ent.ref_cnt + 16'd1;
                    end
                end
                fspa_pkg::MODE_RELEASE:
                begin
                    if (ent.gen != in_reg.cookie_gen)
                    begin
                        new_status = fspa_pkg::ST_STALE;
                    end
                    else if (ent.ref_cnt == '0)
                    begin
                        new_status = fspa_pkg::ST_DOUBLE;
                    end
                    else
                    begin
                        we            = 1'b1;
                        wdata.ref_cnt = ent.ref_cnt - 16'd1;
                        if (ent.ref_cnt == 16'd1)
                        begin
                            use_down   = 1'b1;
                            new_status = fspa_pkg::ST_LAST;
                        end
                    end
                end
                fspa_pkg::MODE_FORCE:
                begin
                    if (ent.ref_cnt == '0)
                    begin
                        new_status = fspa_pkg::ST_DOUBLE;
                    end
                    else
                    begin
                        we            = 1'b1;
                        wdata.ref_cnt = '0;
                        use_down      = 1'b1;
                    end
                end
                fspa_pkg::MODE_LOOKUP:
                begin
                    if (ent.ref_cnt == '0 || ent.gen != in_reg.cookie_gen)
                    begin
                        new_status = fspa_pkg::ST_STALE;
                    end
                    else
                    begin
                        set_birth = 1'b1;
                    end
                end
                default:
                begin
                    new_status = fspa_pkg::ST_BAD;
                end
            endcase
        end
        else if (cmd.scan_step && rd_vld_reg)
        begin
            waddr = chk_reg[AW-1:0];
            if (is_alloc)
            begin
                // first free slot wins
                if (ent.ref_cnt == '0)
                begin
                    we            = 1'b1;
                    wdata.ref_cnt = 16'd1;
                    wdata.gen     = ent.gen + 16'd1;
                    wdata.birth   = in_reg.current_tick;
                    use_up        = 1'b1;
                    set_status    = 1'b1;
                    new_status    = fspa_pkg::ST_OK;
                    set_grant     = 1'b1;
                end
            end
            else if (ent.ref_cnt != '0 && age >= expiry_reg)
            begin
                we            = 1'b1;
                wdata.ref_cnt = '0;
                use_down      = 1'b1;
                exp_inc       = 1'b1;
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.kind       = kind;
        stat.clear_last = (ptr_reg == LAST_PTR);
        stat.scan_done  = (rd_vld_reg && is_alloc && (ent.ref_cnt == '0)) ||
                          (!rd_vld_reg && !issue);
    end

    // Configuration registers, counters and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 7'd64;
            expiry_reg <= '0;
            in_use_reg <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == fspa_pkg::CFG_ACTIVE)
            begin
                active_reg <= cfg_data[6:0];
            end
            if (cfg_we && cfg_index == fspa_pkg::CFG_EXPIRY)
            begin
                expiry_reg <= cfg_data;
            end

            if (use_up && in_use_reg != fspa_pkg::USE_MAX)
            begin
                in_use_reg <= in_use_reg + 7'd1;
            end
            else if (use_down && in_use_reg != '0)
            begin
                in_use_reg <= in_use_reg - 7'd1;
            end

            if (cmd.accept)
            begin
                ptr_reg    <= '0;
                rd_vld_reg <= 1'b0;
            end
            else if (cmd.clr_step)
            begin
                ptr_reg <= ptr_reg + PW'(1);
            end
            else if (cmd.scan_step)
            begin
                rd_vld_reg <= issue;
                if (issue)
                begin
                    ptr_reg <= ptr_reg + PW'(1);
                end
            end
        end
    end

    // Input latch, result fields and output word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_reg          <= req;
            res_gslot_reg   <= '0;
            res_ggen_reg    <= '0;
            res_birth_reg   <= '0;
            res_expired_reg <= '0;
            if (kind == fspa_pkg::K_QUICK)
            begin
                res_status_reg <= quick_status;
            end
            else if (req.mode == fspa_pkg::MODE_ALLOC)
            begin
                res_status_reg <= fspa_pkg::ST_FULL;
            end
            else
            begin
                res_status_reg <= fspa_pkg::ST_OK;
            end
        end
        if (cmd.scan_step)
        begin
            chk_reg <= ptr_reg;
        end
        if (set_status)
        begin
            res_status_reg <= new_status;
        end
        if (set_birth)
        begin
            res_birth_reg <= ent.birth;
        end
        if (set_grant)
        begin
            res_gslot_reg <= chk8[5:0];
            res_ggen_reg  <= wdata.gen;
        end
        if (exp_inc && res_expired_reg != fspa_pkg::EXPIRE_MAX)
        begin
            res_expired_reg <= res_expired_reg + 7'd1;
        end
        if (cmd.load_out)
        begin
            rsp_reg.status        <= res_status_reg;
            rsp_reg.granted_slot  <= res_gslot_reg;
            rsp_reg.granted_gen   <= res_ggen_reg;
            rsp_reg.slot_birth    <= res_birth_reg;
            rsp_reg.expired_count <= res_expired_reg;
            rsp_reg.free_slots    <= free_cnt;
            rsp_reg.used_slots    <= in_use_reg;
        end
    end

    assign rsp = rsp_reg;

    // Slot store: count, generation and birth tick per slot
    fspa_ram #(
        .WIDTH ($bits(fspa_pkg::slot_entry_t)),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ent)
    );

endmodule

>>> hw/rtl/frame_slot_pool_allocator.sv
// Channel   Handshake             Word
// req       req_valid/req_stall   fspa_pkg::in_word_t  (mode, slot, cookie, tick)
// rsp       rsp_valid/rsp_stall   fspa_pkg::out_word_t (status, grant, birth, counts)
// cfg       cfg_we                cfg_index, cfg_data  (active_slots, expiry_ticks)
//
// Ref, release, force_free and lookup do one slot read, then one update.
// Alloc walks slots from 0 at one per cycle and stops at the first free slot,
// or walks every active slot when full. Drop_expired walks every active slot
// unless expiry is disabled. Rejected words and disabled expiry answer
// without a slot read.
// After reset a clearing pass zeroes min(NUM_SLOTS, 128) slots, one per cycle,
// with req_stall high. The result register lets one word wait on rsp_stall
// while the next request is taken.
module frame_slot_pool_allocator #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fspa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  fspa_pkg::in_word_t               req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output fspa_pkg::out_word_t              rsp
);

    fspa_pkg::ctrl_cmd_t cmd;
    fspa_pkg::dp_stat_t  stat;

    // Sequencer
    fspa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Slot store and result logic
    fspa_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule

>>> hw/rtl/fspa_checker.sv
`include "frame_slot_pool_allocator_assert.svh"

module fspa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input fspa_pkg::out_word_t rsp
);

    // A stalled result stays offered and unchanged
    `FSPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
    `FSPA_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp))

    // One request in flight: an accepted word closes the input
    `FSPA_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

    // Failed operations carry no grant, birth tick or expiry count
    `FSPA_ASSERT_IMPL(a_fail_clean, rsp_valid && rsp.status != fspa_pkg::ST_OK,
        rsp.granted_slot == '0 && rsp.granted_gen == '0 &&
        rsp.slot_birth == '0 && rsp.expired_count == '0)

endmodule

bind frame_slot_pool_allocator fspa_checker u_fspa_checker (.*);

>>> tb/tb_frame_slot_pool_allocator.sv
`timescale 1ns / 100ps

module tb_frame_slot_pool_allocator;

    localparam int POOL_SLOTS = 64;
    localparam int VIEW_STIM  = 0;   // pool as seen when words are generated
    localparam int VIEW_LIVE  = 1;   // pool as seen when words are accepted

    // Reserved operation codes, answered as bad argument
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    fspa_pkg::in_word_t              req       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    fspa_pkg::out_word_t             rsp;

    // Pool state, one copy per view
    logic [15:0] cnt_tab   [2][POOL_SLOTS];
    logic [15:0] gen_tab   [2][POOL_SLOTS];
    logic [31:0] birth_tab [2][POOL_SLOTS];
    logic [6:0]  use_cnt   [2];
    logic [6:0]  act_reg   [2];
    logic [31:0] exp_reg   [2];

    fspa_pkg::in_word_t  pending_req [$];
    fspa_pkg::out_word_t due_rsp [$];
    fspa_pkg::out_word_t want_rsp;
    int          mismatch_count = 0;
    logic        quiet = 1'b0;
    logic [31:0] clock_now = '0;
    int unsigned tick_step = 1000;

    frame_slot_pool_allocator #(.NUM_SLOTS(POOL_SLOTS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int eff_count(input int v);
        return (act_reg[v] < POOL_SLOTS) ? int'(act_reg[v]) : POOL_SLOTS;
    endfunction

    // In-use count floors at zero
    function automatic void free_one(input int v);
        if (use_cnt[v] != 7'd0)
            use_cnt[v] = use_cnt[v] - 7'd1;
    endfunction

    // Applies one request word to a view of the pool, returns the response word
    function automatic fspa_pkg::out_word_t pool_apply(input int v,
                                                       input fspa_pkg::in_word_t w);
        fspa_pkg::out_word_t r;
        int          n;
        int          i;
        int          k;
        logic        hit;
        logic [31:0] age;
        r   = '0;
        n   = eff_count(v);
        k   = int'(w.slot_index);
        hit = (k < n);
        case (w.mode)
            fspa_pkg::MODE_ALLOC:
            begin
                r.status = fspa_pkg::ST_FULL;
                for (i = 0; i < n && r.status == fspa_pkg::ST_FULL; i++)
                begin
                    if (cnt_tab[v][i] == 16'd0)
                    begin
                        gen_tab[v][i]   = gen_tab[v][i] + 16'd1;
                        cnt_tab[v][i]   = 16'd1;
                        birth_tab[v][i] = w.current_tick;
                        if (use_cnt[v] < fspa_pkg::USE_MAX)
                            use_cnt[v] = use_cnt[v] + 7'd1;
                        r.status       = fspa_pkg::ST_OK;
                        r.granted_slot = 6'(i);
                        r.granted_gen  = gen_tab[v][i];
                    end
                end
            end
            fspa_pkg::MODE_REF:
            begin
                if (!hit)
                    r.status = fspa_pkg::ST_BAD;
                else if (cnt_tab[v][k] == 16'd0 || gen_tab[v][k] != w.cookie_gen)
                    r.status = fspa_pkg::ST_STALE;
                else if (cnt_tab[v][k] == fspa_pkg::REF_MAX)
                    r.status = fspa_pkg::ST_BAD;
                else
                    cnt_tab[v][k] = cnt_tab[v][k] + 16'd1;
            end
            fspa_pkg::MODE_RELEASE:
            begin
                if (!hit)
                    r.status = fspa_pkg::ST_BAD;
                else if (gen_tab[v][k] != w.cookie_gen)
                    r.status = fspa_pkg::ST_STALE;
                else if (cnt_tab[v][k] == 16'd0)
                    r.status = fspa_pkg::ST_DOUBLE;
                else
                begin
                    cnt_tab[v][k] = cnt_tab[v][k] - 16'd1;
                    if (cnt_tab[v][k] == 16'd0)
                    begin
                        free_one(v);
                        r.status = fspa_pkg::ST_LAST;
                    end
                end
            end
            fspa_pkg::MODE_FORCE:
            begin
                if (!hit)
                    r.status = fspa_pkg::ST_BAD;
                else if (cnt_tab[v][k] == 16'd0)
                    r.status = fspa_pkg::ST_DOUBLE;
                else
                begin
                    cnt_tab[v][k] = 16'd0;
                    free_one(v);
                end
            end
            fspa_pkg::MODE_DROP:
            begin
                // zero timeout turns the sweep off
                if (exp_reg[v] != 32'd0)
                begin
                    for (i = 0; i < n; i++)
                    begin
                        age = w.current_tick - birth_tab[v][i];
                        if (cnt_tab[v][i] != 16'd0 && age >= exp_reg[v])
                        begin
                            cnt_tab[v][i] = 16'd0;
                            free_one(v);
                            if (r.expired_count < fspa_pkg::EXPIRE_MAX)
                                r.expired_count = r.expired_count + 7'd1;
                        end
                    end
                end
            end
            fspa_pkg::MODE_LOOKUP:
            begin
                if (!hit)
                    r.status = fspa_pkg::ST_BAD;
                else if (cnt_tab[v][k] == 16'd0 || gen_tab[v][k] != w.cookie_gen)
                    r.status = fspa_pkg::ST_STALE;
                else
                    r.slot_birth = birth_tab[v][k];
            end
            default:
                r.status = fspa_pkg::ST_BAD;
        endcase
        r.free_slots = (n > int'(use_cnt[v])) ? 7'(n - int'(use_cnt[v])) : 7'd0;
        r.used_slots = use_cnt[v];
        return r;
    endfunction

    // Queues one request word and tracks it in the generation view
    function automatic fspa_pkg::out_word_t issue(input logic [2:0] m,
                                                  input logic [15:0] idx,
                                                  input logic [15:0] ck,
                                                  input logic [31:0] tk);
        fspa_pkg::in_word_t w;
        w.mode         = m;
        w.slot_index   = idx;
        w.cookie_gen   = ck;
        w.current_tick = tk;
        pending_req.push_back(w);
        return pool_apply(VIEW_STIM, w);
    endfunction

    // Mostly live slots, some free or out of range ones
    function automatic logic [15:0] pick_slot();
        int n;
        int i;
        int live [$];
        n = eff_count(VIEW_STIM);
        for (i = 0; i < n; i++)
        begin
            if (cnt_tab[VIEW_STIM][i] != 16'd0)
                live.push_back(i);
        end
        if (live.size() > 0 && $urandom_range(0, 3) != 0)
            return 16'(live[$urandom_range(0, live.size() - 1)]);
        if (n > 0 && $urandom_range(0, 3) != 0)
            return 16'($urandom_range(0, n - 1));
        return 16'($urandom_range(0, 70));
    endfunction

    task automatic random_word();
        int          sel;
        logic [2:0]  m;
        logic [15:0] idx;
        logic [15:0] ck;
        sel       = $urandom_range(0, 99);
        clock_now = clock_now + $urandom_range(0, tick_step);
        // occasional jump so that ages wrap
        if ($urandom_range(0, 39) == 0)
            clock_now = $urandom();
        idx = pick_slot();
        ck  = 16'($urandom());
        if (idx < POOL_SLOTS && $urandom_range(0, 7) != 0)
            ck = gen_tab[VIEW_STIM][idx[5:0]];
        if (sel < 30)
            m = fspa_pkg::MODE_ALLOC;
        else if (sel < 45)
            m = fspa_pkg::MODE_REF;
        else if (sel < 65)
            m = fspa_pkg::MODE_RELEASE;
        else if (sel < 75)
            m = fspa_pkg::MODE_LOOKUP;
        else if (sel < 82)
            m = fspa_pkg::MODE_FORCE;
        else if (sel < 90)
            m = fspa_pkg::MODE_DROP;
        else
        begin
            // noise: any code, any fields
            m   = 3'($urandom_range(0, 7));
            idx = 16'($urandom());
            ck  = 16'($urandom());
        end
        void'(issue(m, idx, ck, clock_now));
    endtask

    // Settled values are read at the falling edge
    task automatic wait_pool_idle();
        do
            @(negedge clk);
        while (pending_req.size() > 0 || req_valid || due_rsp.size() > 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fspa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        wait_pool_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fspa_pkg::CFG_ACTIVE)
        begin
            act_reg[VIEW_STIM] = val[6:0];
            act_reg[VIEW_LIVE] = val[6:0];
        end
        else
        begin
            exp_reg[VIEW_STIM] = val;
            exp_reg[VIEW_LIVE] = val;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Request driver: predicts each accepted word, then offers the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                due_rsp.push_back(pool_apply(VIEW_LIVE, req));
            if (!req_valid || !req_stall)
            begin
                if (pending_req.size() > 0 && (quiet || $urandom_range(0, 99) >= 12))
                begin
                    req_valid <= 1'b1;
                    req       <= pending_req.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 12);
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    mismatch_count++;
                    $error("response word with nothing pending: 0x%0h", rsp);
                end
                else
                begin
                    want_rsp = due_rsp.pop_front();
                    check_field("status", 32'(want_rsp.status), 32'(rsp.status));
                    check_field("granted_slot", 32'(want_rsp.granted_slot),
                                32'(rsp.granted_slot));
                    check_field("granted_gen", 32'(want_rsp.granted_gen),
                                32'(rsp.granted_gen));
                    check_field("slot_birth", want_rsp.slot_birth, rsp.slot_birth);
                    check_field("expired_count", 32'(want_rsp.expired_count),
                                32'(rsp.expired_count));
                    check_field("free_slots", 32'(want_rsp.free_slots),
                                32'(rsp.free_slots));
                    check_field("used_slots", 32'(want_rsp.used_slots),
                                32'(rsp.used_slots));
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("** frame_slot_pool_allocator: FAILED **");
        $finish;
    end

    initial
    begin
        int          s;
        int          p;
        fspa_pkg::out_word_t got;
        int          act_list [8]   = '{64, 127, 7, 0, 64, 1, 33, 64};
        logic [31:0] exp_list [8]   = '{2000, 300, 5000, 100, 0, 50, 32'h8000_0000, 700};
        int          len_list [8]   = '{100, 90, 80, 40, 100, 60, 90, 140};
        logic        calm_list [8]  = '{0, 0, 0, 0, 1, 0, 0, 0};

        for (s = 0; s < POOL_SLOTS; s++)
        begin
            for (p = 0; p < 2; p++)
            begin
                cnt_tab[p][s]   = '0;
                gen_tab[p][s]   = '0;
                birth_tab[p][s] = '0;
            end
        end
        for (p = 0; p < 2; p++)
        begin
            use_cnt[p] = '0;
            act_reg[p] = 7'd64;
            exp_reg[p] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Error paths on an empty pool
        void'(issue(fspa_pkg::MODE_LOOKUP, 16'd0, 16'd0, 32'd0));
        void'(issue(fspa_pkg::MODE_RELEASE, 16'd0, 16'd0, 32'd0));
        void'(issue(fspa_pkg::MODE_RELEASE, 16'd0, 16'hFFFF, 32'd0));
        void'(issue(fspa_pkg::MODE_FORCE, 16'd0, 16'd0, 32'd0));
        void'(issue(fspa_pkg::MODE_REF, 16'd0, 16'd0, 32'd0));
        void'(issue(fspa_pkg::MODE_REF, 16'd64, 16'd0, 32'd0));
        void'(issue(fspa_pkg::MODE_LOOKUP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        void'(issue(fspa_pkg::MODE_FORCE, 16'd63, 16'd0, 32'd0));
        void'(issue(MODE_RSVD6, 16'd1, 16'd1, 32'd1));
        void'(issue(MODE_RSVD7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        // Alloc, ref, lookup, the release chain down to double release, force and drop
        void'(issue(fspa_pkg::MODE_ALLOC, 16'd0, 16'd0, 32'hFFFF_FFFF));
        void'(issue(fspa_pkg::MODE_ALLOC, 16'd0, 16'd0, 32'd0));
        void'(issue(fspa_pkg::MODE_REF, 16'd0, 16'd1, 32'd0));
        void'(issue(fspa_pkg::MODE_LOOKUP, 16'd0, 16'd1, 32'd0));
        void'(issue(fspa_pkg::MODE_LOOKUP, 16'd0, 16'd2, 32'd0));
        void'(issue(fspa_pkg::MODE_RELEASE, 16'd0, 16'd1, 32'd0));
        void'(issue(fspa_pkg::MODE_RELEASE, 16'd0, 16'd1, 32'd0));
        void'(issue(fspa_pkg::MODE_RELEASE, 16'd0, 16'd1, 32'd0));
        void'(issue(fspa_pkg::MODE_FORCE, 16'd1, 16'd0, 32'd0));
        void'(issue(fspa_pkg::MODE_DROP, 16'd0, 16'd0, 32'hFFFF_FFFF));
        wait_pool_idle();

        // Stack references on one slot, no idling on either side
        quiet = 1'b1;
        got = issue(fspa_pkg::MODE_ALLOC, 16'd0, 16'd0, 32'd77);
        repeat (8)
            void'(issue(fspa_pkg::MODE_REF, 16'(got.granted_slot), got.granted_gen, 32'd0));
        void'(issue(fspa_pkg::MODE_REF, 16'(got.granted_slot), got.granted_gen, 32'd0));
        void'(issue(fspa_pkg::MODE_RELEASE, 16'(got.granted_slot), got.granted_gen, 32'd0));
        void'(issue(fspa_pkg::MODE_REF, 16'(got.granted_slot), got.granted_gen, 32'd0));
        void'(issue(fspa_pkg::MODE_REF, 16'(got.granted_slot), got.granted_gen + 16'd1,
                    32'd0));
        void'(issue(fspa_pkg::MODE_LOOKUP, 16'(got.granted_slot), got.granted_gen, 32'd0));
        void'(issue(fspa_pkg::MODE_FORCE, 16'(got.granted_slot), 16'd0, 32'd0));
        wait_pool_idle();
        quiet = 1'b0;

        // Largest and smallest timeouts
        write_reg(fspa_pkg::CFG_EXPIRY, 32'hFFFF_FFFF);
        void'(issue(fspa_pkg::MODE_ALLOC, 16'd0, 16'd0, 32'd1));
        void'(issue(fspa_pkg::MODE_ALLOC, 16'd0, 16'd0, 32'd5));
        void'(issue(fspa_pkg::MODE_DROP, 16'd0, 16'd0, 32'd0));
        write_reg(fspa_pkg::CFG_EXPIRY, 32'd1);
        void'(issue(fspa_pkg::MODE_DROP, 16'd0, 16'd0, 32'd5));
        void'(issue(fspa_pkg::MODE_DROP, 16'd0, 16'd0, 32'd6));

        // Random phases over several pool sizes and timeouts
        for (p = 0; p < 8; p++)
        begin
            write_reg(fspa_pkg::CFG_ACTIVE, ($urandom() & 32'hFFFF_FF80) | 32'(act_list[p]));
            write_reg(fspa_pkg::CFG_EXPIRY, exp_list[p]);
            quiet     = calm_list[p];
            tick_step = (exp_list[p] == 32'd0) ? 1000 : (exp_list[p] >> 3) + 1;
            repeat (len_list[p]) random_word();
        end

        wait_pool_idle();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("** frame_slot_pool_allocator: PASSED **");
        else
            $display("** frame_slot_pool_allocator: FAILED **");
        $finish;
    end

endmodule
